FILE: design/q6k_pkg.sv
// ----------------------------------------------------------------------------
// q6k_pkg - shared types, constants and helpers
// Block geometry, controller/datapath command and status words, float helpers.
// ----------------------------------------------------------------------------
package q6k_pkg;

	localparam int BLOCK_ELEMENTS   = 256;
	localparam int SLICES_PER_BLOCK = BLOCK_ELEMENTS / 4;
	localparam int SLICE_W          = $clog2(SLICES_PER_BLOCK);
	localparam int MANT_W           = 50;   // working mantissa of the float unit
	localparam int LZ_W             = 6;
	localparam int EXP_W            = 12;   // signed working exponent

	localparam logic [31:0] QNAN_DEFAULT = 32'hffc00000;
	localparam logic [31:0] QUIET_BIT    = 32'h00400000;

	// float unit operations
	typedef enum logic [1:0] {
		FP_CVT,
		FP_MUL,
		FP_ADD
	} fp_op_t;

	// steps of the block fold
	typedef enum logic [1:0] {
		FOLD_CVT,    // block sum to fp32
		FOLD_SCALE,  // act scale * weight scale
		FOLD_BLOCK,  // block scale * block sum
		FOLD_ACC     // running total + block product
	} fold_op_t;

	typedef struct packed {
		logic             accept;     // slice word taken this cycle
		logic             first;      // slice 0 of a block
		logic [1:0]       sel;        // {half, position bit 4}
		logic             fp_start;
		fold_op_t         fold_op;
		logic             save_tmp;
		logic             sum_clear;
		logic             total_load;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	// fp16 to fp32, exact
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [3:0]  p;
		logic [9:0]  nman;
		logic [7:0]  e32;
		logic [31:0] r;
		ex   = h[14:10];
		man  = h[9:0];
		p    = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) p = 4'(i);
		end
		nman = man << (4'd10 - p);
		e32  = 8'd103 + {4'd0, p};
		if (ex == 5'd0) begin
			if (man == 10'd0) r = {h[15], 31'd0};
			else r = {h[15], e32, nman, 13'd0};
		end else if (ex == 5'd31) begin
			r = {h[15], 8'hff, man, 13'd0};
		end else begin
			r = {h[15], 3'd0, ex} + 32'd0;
			r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
		end
		return r;
	endfunction

	// leading zero count over the working mantissa
	function automatic logic [LZ_W-1:0] lzc(input logic [MANT_W-1:0] m);
		logic [LZ_W-1:0] n;
		n = LZ_W'(MANT_W);
		for (int i = 0; i < MANT_W; i++) begin
			if (m[i]) n = LZ_W'(MANT_W - 1 - i);
		end
		return n;
	endfunction

endpackage

FILE: design/q6k_q8k_dot_product.sv
// ----------------------------------------------------------------------------
// q6k_q8k_dot_product - 6-bit K-quant weights dotted with 8-bit activations
// Streams 64 slices per 256-element block and emits the fp32 dot product on
// the end-of-vector slice.
// ----------------------------------------------------------------------------
// Slices are taken one per cycle within a block. After the last slice of a
// block (or an end-of-vector slice) the input stalls while the block is
// folded into the fp32 total: a drain step for the integer multiply pipe,
// then four passes through the single shared float unit (sum conversion,
// block scale, block product, total add), and a step to store the total.
// On end of vector a further step loads the result register, and the block
// waits there only while an earlier result is still not taken. The output
// register lets the next vector start while the result waits.
module q6k_q8k_dot_product (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// weight_scale, act_scale, scales_low, scales_high, low_bits_a,
	// low_bits_b, high_bits, activations
	input  logic [231:0] s_tdata,
	input  logic         s_tlast,   // end_of_vector
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata    // dot_result
);

	q6k_pkg::dp_cmd_t cmd;
	q6k_pkg::dp_sts_t sts;

	q6k_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	q6k_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: design/q6k_fp_unit.sv
// ----------------------------------------------------------------------------
// q6k_fp_unit - three-stage fp32 unit
// Multiply, add and int32-to-float with round to nearest even, subnormals
// kept. Stage 1 prepares, stage 2 counts leading zeros, stage 3 rounds.
// ----------------------------------------------------------------------------
module q6k_fp_unit (
	input  logic                  clk,
	input  logic                  start,
	input  q6k_pkg::fp_op_t       op,
	input  logic [31:0]           a,
	input  logic [31:0]           b,
	input  logic [31:0]           ival,
	output logic [31:0]           res
);

	localparam int W = q6k_pkg::MANT_W;
	localparam int E = q6k_pkg::EXP_W;

	logic                 sign_n, zsign_n, spec_n;
	logic [31:0]          specv_n;
	logic signed [E-1:0]  x_n;
	logic [W-1:0]         mant_n;

	logic                 sign_s1, zsign_s1, spec_s1;
	logic [31:0]          specv_s1;
	logic signed [E-1:0]  x_s1;
	logic [W-1:0]         mant_s1;

	logic                 sign_s2, zsign_s2, spec_s2;
	logic [31:0]          specv_s2;
	logic signed [E-1:0]  x_s2;
	logic [W-1:0]         mant_s2;
	logic [q6k_pkg::LZ_W-1:0] lz_s2;

	logic [31:0]          res_s3;

	// operand unpack
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_ge;
	logic [7:0]  ea, eb, el, es, d;
	logic [23:0] ma, mb, ml, ms;
	logic [47:0] prod;
	logic [47:0] wl, ws, wsa, lost;
	logic        stk;
	logic [W-1:0] sumv;
	logic [31:0] mag;

	// stage 1: prepare
	always_comb begin
		sa     = a[31];
		sb     = b[31];
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma     = {a[30:23] != 8'd0, a[22:0]};
		mb     = {b[30:23] != 8'd0, b[22:0]};
		a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		a_zero = a[30:0] == 31'd0;
		b_zero = b[30:0] == 31'd0;
		a_ge   = a[30:0] >= b[30:0];
		el     = a_ge ? ea : eb;
		es     = a_ge ? eb : ea;
		ml     = a_ge ? ma : mb;
		ms     = a_ge ? mb : ma;
		d      = el - es;
		wl     = {ml, 24'd0};
		ws     = {ms, 24'd0};
		prod   = ma * mb;
		mag    = ival[31] ? (32'd0 - ival) : ival;
		if (d >= 8'd48) begin
			wsa  = 48'd0;
			lost = ws;
		end else begin
			wsa  = ws >> d;
			lost = ws & ~({48{1'b1}} << d);
		end
		stk  = |lost;
		wsa  = wsa | {47'd0, stk};
		sumv = ((a_ge ? sa : sb) == (a_ge ? sb : sa)) ?
			({2'b00, wl} + {2'b00, wsa}) : ({2'b00, wl} - {2'b00, wsa});

		sign_n  = 1'b0;
		zsign_n = 1'b0;
		spec_n  = 1'b0;
		specv_n = 32'd0;
		x_n     = '0;
		mant_n  = '0;
		case (op)
			q6k_pkg::FP_CVT: begin
				sign_n = ival[31];
				mant_n = {{(W-32){1'b0}}, mag};
			end
			q6k_pkg::FP_MUL: begin
				sign_n  = sa ^ sb;
				zsign_n = sa ^ sb;
				x_n     = E'({4'd0, ea}) + E'({4'd0, eb}) - E'(300);
				mant_n  = {2'b00, prod};
				spec_n  = 1'b1;
				if (a_nan) specv_n = a | q6k_pkg::QUIET_BIT;
				else if (b_nan) specv_n = b | q6k_pkg::QUIET_BIT;
				else if ((a_inf && b_zero) || (b_inf && a_zero))
					specv_n = q6k_pkg::QNAN_DEFAULT;
				else if (a_inf || b_inf) specv_n = {sa ^ sb, 8'hff, 23'd0};
				else spec_n = 1'b0;
			end
			q6k_pkg::FP_ADD: begin
				sign_n  = a_ge ? sa : sb;
				zsign_n = (a_zero && b_zero) ? (sa & sb) : 1'b0;
				x_n     = E'({4'd0, el}) - E'(174);
				mant_n  = sumv;
				spec_n  = 1'b1;
				if (a_nan) specv_n = a | q6k_pkg::QUIET_BIT;
				else if (b_nan) specv_n = b | q6k_pkg::QUIET_BIT;
				else if (a_inf && b_inf && (sa != sb)) specv_n = q6k_pkg::QNAN_DEFAULT;
				else if (a_inf) specv_n = a;
				else if (b_inf) specv_n = b;
				else spec_n = 1'b0;
			end
			default: begin
				mant_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sign_s1  <= sign_n;
			zsign_s1 <= zsign_n;
			spec_s1  <= spec_n;
			specv_s1 <= specv_n;
			x_s1     <= x_n;
			mant_s1  <= mant_n;
		end
	end

	// stage 2: leading zero count
	always_ff @(posedge clk) begin
		sign_s2  <= sign_s1;
		zsign_s2 <= zsign_s1;
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;
		x_s2     <= x_s1;
		mant_s2  <= mant_s1;
		lz_s2    <= q6k_pkg::lzc(mant_s1);
	end

	// stage 3: normalize and round to nearest even
	logic [W-1:0]        norm, shv, lostm;
	logic signed [E-1:0] be, nrs;
	logic [5:0]          rsh;
	logic [7:0]          field;
	logic                guard, sticky, rnd;
	logic [31:0]         rres;

	always_comb begin
		norm  = mant_s2 << lz_s2;
		be    = x_s2 + E'(176) - E'({{(E-q6k_pkg::LZ_W){1'b0}}, lz_s2});
		nrs   = E'(1) - be;
		rsh   = 6'd0;
		field = be[7:0];
		if (be < E'(1)) begin
			rsh   = (nrs > E'(W)) ? 6'(W) : nrs[5:0];
			field = 8'd0;
		end
		shv    = norm >> rsh;
		lostm  = ~({W{1'b1}} << rsh);
		guard  = shv[25];
		sticky = (|shv[24:0]) | (|(norm & lostm));
		rnd    = guard & (sticky | shv[26]);
		rres   = {sign_s2, field, shv[48:26]} + {31'd0, rnd};
		if (spec_s2) rres = specv_s2;
		else if (mant_s2 == '0) rres = {zsign_s2, 31'd0};
		else if (be >= E'(255)) rres = {sign_s2, 8'hff, 23'd0};
	end

	always_ff @(posedge clk) begin
		res_s3 <= rres;
	end

	assign res = res_s3;

endmodule

FILE: design/q6k_datapath.sv
// ----------------------------------------------------------------------------
// q6k_datapath - integer slice pipeline, scale store and float fold
// Two-stage integer multiply-accumulate per slice, per-lane group scales,
// fp32 fold through the shared float unit, and the result register.
// ----------------------------------------------------------------------------
module q6k_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  q6k_pkg::dp_cmd_t  cmd,
	output q6k_pkg::dp_sts_t  sts,
	input  logic [231:0]      s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata
);

	logic [15:0] weight_scale;
	logic [31:0] act_scale;
	logic [63:0] scales_low, scales_high;
	logic [7:0]  low_bits_a, low_bits_b, high_bits;
	logic [31:0] activations;

	assign weight_scale = s_tdata[15:0];
	assign act_scale    = s_tdata[47:16];
	assign scales_low   = s_tdata[111:48];
	assign scales_high  = s_tdata[175:112];
	assign low_bits_a   = s_tdata[183:176];
	assign low_bits_b   = s_tdata[191:184];
	assign high_bits    = s_tdata[199:192];
	assign activations  = s_tdata[231:200];

	// lane k holds groups 2k, 2k+1, 8+2k, 9+2k
	logic [7:0]  lane_q [4][4];
	logic [31:0] act_q, half_q;

	logic [5:0]          qv [4];
	logic signed [6:0]   wv [4];
	logic signed [7:0]   av [4];
	logic signed [7:0]   sv [4];
	logic signed [14:0]  p_s1 [4];
	logic signed [7:0]   sc_s1 [4];
	logic                v_s1;

	always_comb begin
		qv[0] = {high_bits[1:0], low_bits_a[3:0]};
		qv[1] = {high_bits[3:2], low_bits_b[3:0]};
		qv[2] = {high_bits[5:4], low_bits_a[7:4]};
		qv[3] = {high_bits[7:6], low_bits_b[7:4]};
		for (int k = 0; k < 4; k++) begin
			wv[k] = $signed({1'b0, qv[k]}) - 7'sd32;
			av[k] = $signed(activations[8*k +: 8]);
			sv[k] = cmd.first ? $signed(scales_low[16*k +: 8]) : $signed(lane_q[k][cmd.sel]);
		end
	end

	// scale store and block scale operands, taken on slice 0
	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.first) begin
			for (int k = 0; k < 4; k++) begin
				lane_q[k][0] <= scales_low[16*k +: 8];
				lane_q[k][1] <= scales_low[16*k+8 +: 8];
				lane_q[k][2] <= scales_high[16*k +: 8];
				lane_q[k][3] <= scales_high[16*k+8 +: 8];
			end
			act_q  <= act_scale;
			half_q <= q6k_pkg::half_to_single(weight_scale);
		end
	end

	// stage 1: weight times activation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			p_s1[k]  <= wv[k] * av[k];
			sc_s1[k] <= sv[k];
		end
	end

	// stage 2: times group scale, into the block sum
	logic signed [22:0] t [4];
	logic signed [24:0] tsum;
	logic [31:0]        block_sum_q;

	always_comb begin
		tsum = '0;
		for (int k = 0; k < 4; k++) begin
			t[k] = p_s1[k] * sc_s1[k];
			tsum = tsum + 25'(t[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= 32'd0;
		end else if (cmd.sum_clear) begin
			block_sum_q <= 32'd0;
		end else if (v_s1) begin
			block_sum_q <= block_sum_q + {{7{tsum[24]}}, tsum};
		end
	end

	// fold through the float unit
	q6k_pkg::fp_op_t fop;
	logic [31:0]     fa, fb, fres, tmp_q, total_q;

	always_comb begin
		fop = q6k_pkg::FP_CVT;
		fa  = fres;
		fb  = tmp_q;
		case (cmd.fold_op)
			q6k_pkg::FOLD_CVT:   fop = q6k_pkg::FP_CVT;
			q6k_pkg::FOLD_SCALE: begin
				fop = q6k_pkg::FP_MUL;
				fa  = act_q;
				fb  = half_q;
			end
			q6k_pkg::FOLD_BLOCK: begin
				fop = q6k_pkg::FP_MUL;
				fa  = fres;
				fb  = tmp_q;
			end
			q6k_pkg::FOLD_ACC: begin
				fop = q6k_pkg::FP_ADD;
				fa  = total_q;
				fb  = fres;
			end
			default: fop = q6k_pkg::FP_CVT;
		endcase
	end

	q6k_fp_unit u_fp (
		.clk    (clk),
		.start  (cmd.fp_start),
		.op     (fop),
		.a      (fa),
		.b      (fb),
		.ival   (block_sum_q),
		.res    (fres)
	);

	always_ff @(posedge clk) begin
		if (cmd.save_tmp) tmp_q <= fres;
	end

	// running total and result register
	logic        m_tvalid_q;
	logic [31:0] dout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 32'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.total_load) total_q <= fres;
			else if (cmd.out_load) total_q <= 32'd0;
			if (cmd.out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) dout_q <= total_q;
	end

	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = dout_q;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

FILE: design/q6k_ctrl.sv
// ----------------------------------------------------------------------------
// q6k_ctrl - slice counter and fold sequencer
// Takes slices while running, then steps the float unit through the fold.
// ----------------------------------------------------------------------------
module q6k_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tlast,
	input  q6k_pkg::dp_sts_t  sts,
	output q6k_pkg::dp_cmd_t  cmd
);

	localparam int SW = q6k_pkg::SLICE_W;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_CVT,
		ST_SCALE,
		ST_BLOCK,
		ST_ACC,
		ST_DONE,
		ST_OUT
	} state_t;

	state_t        state_q;
	logic [SW-1:0] slice_q;
	logic [1:0]    cnt_q;
	logic          eov_q;
	logic          acc, op_state;

	assign acc      = s_tvalid && (state_q == ST_RUN);
	assign s_tready = state_q == ST_RUN;
	assign op_state = (state_q == ST_CVT) || (state_q == ST_SCALE) ||
		(state_q == ST_BLOCK) || (state_q == ST_ACC);

	// state, slice count and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			slice_q <= '0;
			cnt_q   <= 2'd0;
			eov_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (acc) begin
						if (s_tlast || slice_q == SW'(q6k_pkg::SLICES_PER_BLOCK - 1)) begin
							eov_q   <= s_tlast;
							slice_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							slice_q <= slice_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					cnt_q   <= 2'd0;
					state_q <= ST_CVT;
				end
				ST_CVT, ST_SCALE, ST_BLOCK, ST_ACC: begin
					if (cnt_q == 2'd2) begin
						cnt_q <= 2'd0;
						case (state_q)
							ST_CVT:   state_q <= ST_SCALE;
							ST_SCALE: state_q <= ST_BLOCK;
							ST_BLOCK: state_q <= ST_ACC;
							default:  state_q <= ST_DONE;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					state_q <= eov_q ? ST_OUT : ST_RUN;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.accept     = acc;
		cmd.first      = slice_q == '0;
		cmd.sel        = slice_q[SW-1 -: 2];
		cmd.fp_start   = op_state && (cnt_q == 2'd0);
		cmd.save_tmp   = (state_q == ST_SCALE) && (cnt_q == 2'd0);
		cmd.sum_clear  = (state_q == ST_CVT) && (cnt_q == 2'd0);
		cmd.total_load = state_q == ST_DONE;
		cmd.out_load   = (state_q == ST_OUT) && sts.out_free;
		case (state_q)
			ST_SCALE: cmd.fold_op = q6k_pkg::FOLD_SCALE;
			ST_BLOCK: cmd.fold_op = q6k_pkg::FOLD_BLOCK;
			ST_ACC:   cmd.fold_op = q6k_pkg::FOLD_ACC;
			default:  cmd.fold_op = q6k_pkg::FOLD_CVT;
		endcase
	end

endmodule

FILE: design/q6k_checker.sv
// ----------------------------------------------------------------------------
// q6k_checker - port-level checks for the dot product block
// Watches the stream ports for sequencing errors.
// ----------------------------------------------------------------------------
module q6k_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tlast,
	input logic m_tvalid,
	input logic m_tready
);

	// a result is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before taken");

	// input only stops after a taken word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input stalled without a word");

	// end of vector always starts a fold
	a_eov_fold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("no fold after end of vector");

	// a result only appears out of a fold
	a_out_from_fold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without fold");

endmodule

bind q6k_q8k_dot_product q6k_checker u_q6k_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

FILE: tb/q6k_q8k_dot_product_tb.sv
// ----------------------------------------------------------------------------
// q6k_q8k_dot_product_tb - self-checking bench for the Q6_K x Q8_K dot product
// Streams vectors of 6-bit weight slices, from one slice to several blocks,
// under changing sender gaps and receiver stalls. Each accepted slice goes
// into a bit-exact fp32 predictor, and every dot_result is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module q6k_q8k_dot_product_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TARGET_SLICES  = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [231:0] s_tdata;    // weight_scale, act_scale, scales_low, scales_high,
	                          // low_bits_a, low_bits_b, high_bits, activations
	logic         s_tlast;    // end_of_vector
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;    // dot_result

	int idle_pct;
	int stall_pct;
	int slices_sent;
	int quiet_cycles;

	q6k_q8k_dot_product i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// fp32 helpers: values go through double, which holds fp32 products
	// exactly and rounds fp32 sums correctly, then back with RNE.
	// ------------------------------------------------------------------
	function automatic logic sp_is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
	endfunction

	function automatic real sp_to_real(input logic [31:0] b);
		real r;
		if (b[30:23] == 8'd0) begin
			if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
			r = $itor(b[22:0]) * (2.0 ** (-149));
			return b[31] ? -r : r;
		end
		if (b[30:23] == 8'hff) return $bitstoreal({b[31], 11'h7ff, 52'd0});
		return $bitstoreal({b[31], 11'({3'd0, b[30:23]} + 11'd896), b[22:0], 29'd0});
	endfunction

	function automatic logic [31:0] real_to_sp(input real r);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] halfway;
		logic        s;
		int          e;
		int          sh;
		d = $realtobits(r);
		s = d[63];
		if (d[62:52] == 11'h7ff) begin
			if (d[51:0] != 52'd0) return q6k_pkg::QNAN_DEFAULT;
			return {s, 8'hff, 23'd0};
		end
		if (d[62:52] == 11'd0) return {s, 31'd0};
		e   = int'(d[62:52]) - 1023;
		sig = {11'd0, 1'b1, d[51:0]};
		if (e > 127) return {s, 8'hff, 23'd0};
		sh = (e >= -126) ? 29 : 29 + (-126 - e);
		if (sh > 60) return {s, 31'd0};
		q       = sig >> sh;
		rem     = sig & ((64'd1 << sh) - 64'd1);
		halfway = 64'd1 << (sh - 1);
		if (rem > halfway || (rem == halfway && q[0])) q = q + 64'd1;
		if (e >= -126) begin
			if (q[24]) begin
				q = q >> 1;
				e = e + 1;
			end
			if (e > 127) return {s, 8'hff, 23'd0};
			return {s, 8'(e + 127), q[22:0]};
		end
		// subnormal; a carry into bit 23 lands on the smallest normal
		return {s, q[30:0]};
	endfunction

	// NaN operands come back quieted, the first one winning
	function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
		if (sp_is_nan(a)) return a | q6k_pkg::QUIET_BIT;
		if (sp_is_nan(b)) return b | q6k_pkg::QUIET_BIT;
		return real_to_sp(sp_to_real(a) * sp_to_real(b));
	endfunction

	function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
		if (sp_is_nan(a)) return a | q6k_pkg::QUIET_BIT;
		if (sp_is_nan(b)) return b | q6k_pkg::QUIET_BIT;
		return real_to_sp(sp_to_real(a) + sp_to_real(b));
	endfunction

	function automatic logic [31:0] fp16_widen(input logic [15:0] h);
		logic [10:0] man;
		logic [7:0]  ex;
		man = {1'b0, h[9:0]};
		if (h[14:10] == 5'd0) begin
			if (man == 11'd0) return {h[15], 31'd0};
			ex = 8'd113;
			while (!man[10]) begin
				man = man << 1;
				ex  = ex - 8'd1;
			end
			return {h[15], ex, man[9:0], 13'd0};
		end
		if (h[14:10] == 5'd31) return {h[15], 8'hff, h[9:0], 13'd0};
		return {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: dot product predictor plus queue of pending totals
	// ------------------------------------------------------------------
	class dot_scoreboard;
		logic [31:0]       pending_totals[$];
		int                errors;
		logic [5:0]        slice_idx;
		logic signed [7:0] grp_scale[16];
		logic [31:0]       blk_scale;
		int                blk_sum;
		logic [31:0]       total;

		function new();
			errors    = 0;
			slice_idx = 6'd0;
			blk_scale = 32'd0;
			blk_sum   = 0;
			total     = 32'd0;
			foreach (grp_scale[i]) grp_scale[i] = 8'sd0;
		endfunction

		function void note_slice(input logic [231:0] d, input logic eov);
			logic [7:0]  la;
			logic [7:0]  lb;
			logic [7:0]  hb;
			logic [5:0]  q[4];
			logic [3:0]  gbase;
			int          w;
			int          a;
			int          sc;
			la = d[183:176];
			lb = d[191:184];
			hb = d[199:192];
			// first slice latches group scales and the block scale
			if (slice_idx == 6'd0) begin
				for (int k = 0; k < 8; k++) begin
					grp_scale[k]     = d[48 + 8*k +: 8];
					grp_scale[8 + k] = d[112 + 8*k +: 8];
				end
				blk_scale = sp_mul(d[47:16], fp16_widen(d[15:0]));
				blk_sum   = 0;
			end
			q[0] = {hb[1:0], la[3:0]};
			q[1] = {hb[3:2], lb[3:0]};
			q[2] = {hb[5:4], la[7:4]};
			q[3] = {hb[7:6], lb[7:4]};
			gbase = {slice_idx[5], 2'b00, slice_idx[4]};
			for (int k = 0; k < 4; k++) begin
				w  = int'(q[k]) - 32;
				a  = int'($signed(d[200 + 8*k +: 8]));
				sc = int'(grp_scale[4'(gbase + 4'(2*k))]);
				blk_sum += w * a * sc;
			end
			// fold on the last slice of a block or on end of vector
			if (slice_idx == 6'd63 || eov) begin
				total     = sp_add(total, sp_mul(blk_scale, real_to_sp($itor(blk_sum))));
				blk_sum   = 0;
				slice_idx = 6'd0;
			end else begin
				slice_idx = slice_idx + 6'd1;
			end
			if (eov) begin
				pending_totals.push_back(total);
				total = 32'd0;
			end
		endfunction

		function void check_result(input logic [31:0] got);
			logic [31:0] want;
			if (pending_totals.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected dot_result %h", got);
				return;
			end
			want = pending_totals.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: dot_result expected %h, got %h", want, got);
			end
		endfunction
	endclass

	dot_scoreboard sb;

	// ------------------------------------------------------------------
	// Monitors and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_slice(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic send_slice(input logic [231:0] d, input logic eov);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = d;
		s_tlast  = eov;
		do @(posedge clk); while (!s_tready);
		slices_sent++;
	endtask

	function automatic logic [231:0] random_slice();
		logic [15:0] wscale;
		logic [31:0] ascale;
		logic [231:0] d;
		wscale = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
		ascale = ($urandom_range(0, 7) == 0) ? $urandom
			: {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
		d = 232'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		d[15:0]  = wscale;
		d[47:16] = ascale;
		return d;
	endfunction

	// a vector of full blocks, optionally followed by tail slices of one more block
	task automatic send_vector(input int full_blocks, input int tail);
		int n;
		n = full_blocks * 64 + tail;
		for (int i = 0; i < n; i++) send_slice(random_slice(), i == n - 1);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_totals.size() != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		slices_sent  = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: short vectors at the field extremes and float specials
		send_slice('0, 1'b1);
		send_slice('1, 1'b1);
		// all weights 63, scales and activations -128
		send_slice({32'h80808080, 8'hff, 8'hff, 8'hff, {16{8'h80}}, 32'h3f800000,
			16'h3c00}, 1'b1);
		// all weights 0 (-32 after offset), scales and activations +127
		send_slice({32'h7f7f7f7f, 24'd0, {16{8'h7f}}, 32'h3f800000, 16'h3c00}, 1'b1);
		// subnormal fp16 against the largest fp32
		send_slice({32'h01020304, 24'h123456, {16{8'h01}}, 32'h7f7fffff, 16'h0001},
			1'b1);
		// infinite weight scale times zero activation scale
		send_slice({32'h11111111, 24'h555555, {16{8'h02}}, 32'h00000000, 16'h7c00},
			1'b1);
		// negative weight scale, early end after three slices
		send_slice({32'h0a0b0c0d, 24'h9a7c3e, {16{8'hfe}}, 32'h40000000, 16'h8400},
			1'b0);
		send_slice({32'hf0e0d0c0, 24'h13579b, 128'd0, 32'd0, 16'd0}, 1'b0);
		send_slice({32'h7f807f80, 24'hfedcba, 128'd0, 32'd0, 16'd0}, 1'b1);
		// huge activation scale overflowing the total
		send_slice({32'h7f7f7f7f, 24'hffffff, {16{8'h7f}}, 32'h7f000000, 16'h7bff},
			1'b1);
		drain_results();

		// random vectors in four idling phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
			endcase
			while (slices_sent < (phase + 1) * TARGET_SLICES / 4) begin
				pick = $urandom_range(0, 9);
				if (pick <= 5) send_vector(0, $urandom_range(1, 40));
				else if (pick <= 7) send_vector(0, 64);
				else if (pick == 8) send_vector(2, $urandom_range(1, 64));
				else send_vector(2, 0);
			end
			// hold the sender until every pending result is out
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_totals.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
